// ===== sv/rbst_pkg.sv =====
// Package: shared constants for the ray/box slab test pipeline.
`default_nettype none
package rbst_pkg;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int NUM_AXES        = 3;
   localparam int NUM_LANES       = 2 * NUM_AXES;
   localparam int PREP_STAGES     = 2;
   localparam int FINISH_STAGES   = 4;
endpackage
`default_nettype wire

// ===== sv/rbst_prep.sv =====
// Front end: slab distances numerators, magnitudes, signs and divider setup.
`default_nettype none
module rbst_prep import rbst_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic signed [COORD_WIDTH-1:0] org  [NUM_AXES],
   input  wire logic signed [COORD_WIDTH-1:0] dir  [NUM_AXES],
   input  wire logic signed [COORD_WIDTH-1:0] bmin [NUM_AXES],
   input  wire logic        [COORD_WIDTH-2:0] bsize[NUM_AXES],
   output logic             [COORD_WIDTH-1:0] r0   [NUM_LANES],
   output logic             [COORD_WIDTH-1:0] low  [NUM_LANES],
   output logic             [COORD_WIDTH-1:0] den  [NUM_LANES],
   output logic                               qneg [NUM_LANES],
   output logic                               ovf  [NUM_LANES],
   output logic                               dzero[NUM_AXES],
   output logic                               pass [NUM_AXES]
);
   localparam int W  = COORD_WIDTH;
   localparam int PW = W + 2;
   localparam int MW = W + 1;
   localparam int NW = MW + FRAC_BITS;
   localparam int HW = FRAC_BITS + 1;
   localparam int CW = (HW > W) ? HW : W;

   logic signed [PW-1:0] a_ff [NUM_AXES];
   logic signed [PW-1:0] b_ff [NUM_AXES];
   logic        [W-1:0]  d_ff [NUM_AXES];
   logic                 dn_ff[NUM_AXES];
   logic                 dz_ff[NUM_AXES];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            a_ff[i]  <= PW'(bmin[i]) - PW'(org[i]);
            b_ff[i]  <= PW'(bmin[i]) - PW'(org[i]) + PW'({1'b0, bsize[i]});
            d_ff[i]  <= dir[i][W-1] ? W'(-dir[i]) : W'(dir[i]);
            dn_ff[i] <= dir[i][W-1];
            dz_ff[i] <= (dir[i] == '0);
         end
      end
   end

   logic [MW-1:0] mag [NUM_LANES];
   logic          nneg[NUM_LANES];
   logic [NW-1:0] num [NUM_LANES];

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         nneg[2*i]   = a_ff[i][PW-1];
         nneg[2*i+1] = b_ff[i][PW-1];
         mag[2*i]    = a_ff[i][PW-1] ? MW'(-a_ff[i]) : MW'(a_ff[i]);
         mag[2*i+1]  = b_ff[i][PW-1] ? MW'(-b_ff[i]) : MW'(b_ff[i]);
      end
      for (int l = 0; l < NUM_LANES; l++) begin
         num[l] = {mag[l], {FRAC_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            r0[l]   <= W'(num[l][NW-1:W]);
            low[l]  <= num[l][W-1:0];
            den[l]  <= d_ff[l/2];
            qneg[l] <= nneg[l] ^ dn_ff[l/2];
            ovf[l]  <= CW'(num[l][NW-1:W]) >= CW'(d_ff[l/2]);
         end
         for (int i = 0; i < NUM_AXES; i++) begin
            dzero[i] <= dz_ff[i];
            pass[i]  <= !dz_ff[i] || (a_ff[i] <= 0 && b_ff[i] >= 0);
         end
      end
   end
endmodule
`default_nettype wire

// ===== sv/rbst_div.sv =====
// Restoring divider lane, one quotient bit per pipeline stage.
`default_nettype none
module rbst_div import rbst_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire logic [COORD_WIDTH-1:0] r0,
   input  wire logic [COORD_WIDTH-1:0] low,
   input  wire logic [COORD_WIDTH-1:0] den,
   output logic      [COORD_WIDTH-1:0] quo
);
   localparam int W = COORD_WIDTH;

   logic [W-1:0] r_ff [1:W];
   logic [W-1:0] l_ff [1:W];
   logic [W-1:0] d_ff [1:W];
   logic [W-1:0] q_ff [1:W];

   for (genvar k = 0; k < W; k++) begin : g_step
      logic [W-1:0] r_cur;
      logic [W-1:0] l_cur;
      logic [W-1:0] d_cur;
      logic [W-1:0] q_cur;
      logic [W:0]   r2;
      logic         ge;
      if (k == 0) begin : g_first
         assign r_cur = r0;
         assign l_cur = low;
         assign d_cur = den;
         assign q_cur = '0;
      end else begin : g_next
         assign r_cur = r_ff[k];
         assign l_cur = l_ff[k];
         assign d_cur = d_ff[k];
         assign q_cur = q_ff[k];
      end
      always_comb begin
         r2 = {r_cur, l_cur[W-1]};
         ge = r2 >= {1'b0, d_cur};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k+1] <= ge ? W'(r2 - {1'b0, d_cur}) : W'(r2);
            l_ff[k+1] <= {l_cur[W-2:0], 1'b0};
            d_ff[k+1] <= d_cur;
            q_ff[k+1] <= {q_cur[W-2:0], ge};
         end
      end
   end

   assign quo = q_ff[W];
endmodule
`default_nettype wire

// ===== sv/rbst_reduce.sv =====
// Back end: saturate and sign distances, order slabs, narrow the interval.
`default_nettype none
module rbst_reduce import rbst_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire logic [COORD_WIDTH-1:0] quo  [NUM_LANES],
   input  wire logic                   qneg [NUM_LANES],
   input  wire logic                   ovf  [NUM_LANES],
   input  wire logic                   dzero[NUM_AXES],
   input  wire logic                   pass [NUM_AXES],
   output logic                        hit
);
   localparam int W = COORD_WIDTH;
   localparam logic signed [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};

   logic signed [W-1:0] t_ff  [NUM_LANES];
   logic                dz1_ff[NUM_AXES];
   logic                ps1_ff;
   logic signed [W-1:0] tn_ff [NUM_AXES];
   logic signed [W-1:0] tf_ff [NUM_AXES];
   logic                ps2_ff;
   logic signed [W-1:0] tmin_ff, tmax_ff;
   logic                ps3_ff;
   logic [W-1:0]        cap [NUM_LANES];
   logic [W-1:0]        val [NUM_LANES];
   logic signed [W-1:0] m0, m1, n0, n1;

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         cap[l] = qneg[l] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         val[l] = (ovf[l] || quo[l] > cap[l]) ? cap[l] : quo[l];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            t_ff[l] <= qneg[l] ? W'(-val[l]) : val[l];
         end
         for (int i = 0; i < NUM_AXES; i++) begin
            dz1_ff[i] <= dzero[i];
         end
         ps1_ff <= pass[0] && pass[1] && pass[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            if (dz1_ff[i]) begin
               tn_ff[i] <= '0;
               tf_ff[i] <= MAXPOS;
            end else if (t_ff[2*i+1] < t_ff[2*i]) begin
               tn_ff[i] <= t_ff[2*i+1];
               tf_ff[i] <= t_ff[2*i];
            end else begin
               tn_ff[i] <= t_ff[2*i];
               tf_ff[i] <= t_ff[2*i+1];
            end
         end
         ps2_ff <= ps1_ff;
      end
   end

   always_comb begin
      m0 = (tn_ff[0] > 0) ? tn_ff[0] : '0;
      m1 = (tn_ff[1] > tn_ff[2]) ? tn_ff[1] : tn_ff[2];
      n0 = (tf_ff[0] < MAXPOS) ? tf_ff[0] : MAXPOS;
      n1 = (tf_ff[1] < tf_ff[2]) ? tf_ff[1] : tf_ff[2];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tmin_ff <= (m1 > m0) ? m1 : m0;
         tmax_ff <= (n1 < n0) ? n1 : n0;
         ps3_ff  <= ps2_ff;
         hit     <= ps3_ff && !(tmax_ff < tmin_ff);
      end
   end
endmodule
`default_nettype wire

// ===== sv/ray_box_slab_test.sv =====
// Top level: pipelined ray versus axis-aligned box slab test.
// Takes one request per cycle while the response side is not stalled and returns one hit flag
// per request, in order. The pipeline has two setup stages, one stage per quotient
// bit in the six restoring divider lanes, and four stages of saturation, slab
// ordering and interval narrowing. A stalled response holds the whole pipeline
// in place.
`default_nettype none
module ray_box_slab_test import rbst_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   localparam int REQ_BITS   = 12 * COORD_WIDTH - 3,
   localparam int REQ_WIDTH  = ((REQ_BITS + 7) / 8) * 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
   // box_min_x, box_min_y, box_min_z, box_size_x, box_size_y, box_size_z
   input  wire logic [REQ_WIDTH-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // hit
   output logic [7:0]                rsp_tdata
);
   localparam int W   = COORD_WIDTH;
   localparam int LAT = PREP_STAGES + W + FINISH_STAGES;

   logic en;
   logic vld_ff [LAT];
   logic signed [W-1:0] org [NUM_AXES];
   logic signed [W-1:0] dir [NUM_AXES];
   logic signed [W-1:0] bmin[NUM_AXES];
   logic        [W-2:0] bsz [NUM_AXES];
   logic [W-1:0] r0 [NUM_LANES];
   logic [W-1:0] low[NUM_LANES];
   logic [W-1:0] den[NUM_LANES];
   logic [W-1:0] quo[NUM_LANES];
   logic qneg_p[NUM_LANES];
   logic ovf_p [NUM_LANES];
   logic dz_p  [NUM_AXES];
   logic pass_p[NUM_AXES];
   logic qneg_ff[W][NUM_LANES];
   logic ovf_ff [W][NUM_LANES];
   logic dz_ff  [W][NUM_AXES];
   logic pass_ff[W][NUM_AXES];
   logic hit;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = {7'b0, hit};

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         org[i]  = req_tdata[i*W +: W];
         dir[i]  = req_tdata[(NUM_AXES+i)*W +: W];
         bmin[i] = req_tdata[(2*NUM_AXES+i)*W +: W];
         bsz[i]  = req_tdata[3*NUM_AXES*W + i*(W-1) +: W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LAT; s++) vld_ff[s] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int s = 1; s < LAT; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   rbst_prep #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_prep (
      .clock, .en, .org, .dir, .bmin, .bsize(bsz),
      .r0, .low, .den, .qneg(qneg_p), .ovf(ovf_p), .dzero(dz_p), .pass(pass_p)
   );

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      rbst_div #(.COORD_WIDTH(W)) u_div (
         .clock, .en, .r0(r0[l]), .low(low[l]), .den(den[l]), .quo(quo[l])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qneg_ff[0] <= qneg_p;
         ovf_ff[0]  <= ovf_p;
         dz_ff[0]   <= dz_p;
         pass_ff[0] <= pass_p;
         for (int s = 1; s < W; s++) begin
            qneg_ff[s] <= qneg_ff[s-1];
            ovf_ff[s]  <= ovf_ff[s-1];
            dz_ff[s]   <= dz_ff[s-1];
            pass_ff[s] <= pass_ff[s-1];
         end
      end
   end

   rbst_reduce #(.COORD_WIDTH(W)) u_reduce (
      .clock, .en, .quo, .qneg(qneg_ff[W-1]), .ovf(ovf_ff[W-1]),
      .dzero(dz_ff[W-1]), .pass(pass_ff[W-1]), .hit
   );

   a_reset_clears: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[0])
      else $error("accepted request lost at pipeline entry");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(hit))
      else $error("result changed during stall");
endmodule
`default_nettype wire

// ===== tb/sv/ray_box_slab_check.sv =====
// Hit predictor and in-order scoreboard for the ray/box slab test block.
`timescale 1ns / 1ps
`default_nettype none
module ray_box_slab_check #(
   parameter int REQ_WIDTH = 384
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_tready,
   input  wire logic [REQ_WIDTH-1:0] req_tdata,
   input  wire logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire logic [7:0]           rsp_tdata,
   output int                        fail_count,
   output int                        pending
);
   localparam int CW = 32;
   localparam int FB = 16;
   localparam longint signed T_HI = 64'sd2147483647;
   localparam longint signed T_LO = -64'sd2147483648;

   bit hit_queue[$];

   // truncated, saturated (num << FB) / den
   function automatic longint signed slab_dist(longint signed num, longint signed den);
      logic [127:0] mag_n;
      logic [127:0] quo;
      logic         neg;
      longint signed q;
      begin
         neg   = (num < 0) != (den < 0);
         mag_n = 128'(num < 0 ? -num : num) << FB;
         quo   = mag_n / 128'(den < 0 ? -den : den);
         if (neg) begin
            q = (quo > 128'(64'd2147483648)) ? T_LO : -longint'(quo);
         end else begin
            q = (quo > 128'(T_HI)) ? T_HI : longint'(quo);
         end
         return q;
      end
   endfunction

   function automatic bit ray_hits(logic [REQ_WIDTH-1:0] d);
      longint signed t_near, t_far, org, dir, bmin, bsz, a, b, tn, tf, tmp;
      bit hit;
      begin
         t_near = 0;
         t_far  = T_HI;
         hit    = 1'b1;
         for (int ax = 0; ax < 3; ax++) begin
            org  = longint'($signed(d[ax*CW +: CW]));
            dir  = longint'($signed(d[(3+ax)*CW +: CW]));
            bmin = longint'($signed(d[(6+ax)*CW +: CW]));
            bsz  = longint'({33'd0, d[9*CW + ax*(CW-1) +: CW-1]});
            a = bmin - org;
            b = a + bsz;
            if (dir == 0) begin
               if (a > 0 || b < 0) hit = 1'b0;
            end else begin
               tn = slab_dist(a, dir);
               tf = slab_dist(b, dir);
               if (tf < tn) begin
                  tmp = tn; tn = tf; tf = tmp;
               end
               if (tn > t_near) t_near = tn;
               if (tf < t_far) t_far = tf;
               if (t_far < t_near) hit = 1'b0;
            end
         end
         return hit;
      end
   endfunction

   always @(posedge clock) begin
      bit want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) hit_queue.push_back(ray_hits(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (hit_queue.size() == 0) begin
               $display("%0t: unexpected hit response, expected none, actual %h",
                        $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = hit_queue.pop_front();
               if (rsp_tdata !== {7'd0, want}) begin
                  $display("%0t: hit mismatch, expected %h, actual %h",
                           $time, {7'd0, want}, rsp_tdata);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending = hit_queue.size();
   end
endmodule
`default_nettype wire

// ===== tb/sv/ray_box_slab_test_test.sv =====
// Stimulus and verdict for the ray/box slab test block.
`timescale 1ns / 1ps
`default_nettype none
module ray_box_slab_test_test;
   import rbst_pkg::*;
   localparam int CW = 32;
   localparam int REQ_WIDTH = ((12 * CW - 3 + 7) / 8) * 8;
   localparam int LIMIT = 200000;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_WIDTH-1:0] req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [7:0]           rsp_tdata;
   int                   fail_count;
   int                   pending;
   int                   cycles;
   bit                   calm;

   ray_box_slab_test u_top (.*);

   ray_box_slab_check #(.REQ_WIDTH(REQ_WIDTH)) u_check (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver stalls in bursts
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         n = $urandom_range(1, 8);
         rsp_tready = calm || $urandom_range(0, 2) != 0;
         repeat (n) @(negedge clock);
         if (calm) rsp_tready = 1'b1;
      end
   end

   function automatic logic [31:0] pick_coord(int span);
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'd0;
         3: return $urandom;
         default: return 32'($signed($urandom_range(0, 2 * span)) - span);
      endcase
   endfunction

   function automatic logic [30:0] pick_size(int span);
      case ($urandom_range(0, 7))
         0: return 31'h7fff_ffff;
         1: return 31'd0;
         2: return 31'($urandom);
         default: return 31'($urandom_range(0, span));
      endcase
   endfunction

   task automatic send_ray(logic [31:0] o[3], logic [31:0] d[3],
                           logic [31:0] m[3], logic [30:0] s[3]);
      logic [REQ_WIDTH-1:0] w;
      w = '0;
      for (int i = 0; i < 3; i++) begin
         w[i*CW +: CW]         = o[i];
         w[(3+i)*CW +: CW]     = d[i];
         w[(6+i)*CW +: CW]     = m[i];
         w[9*CW + i*31 +: 31]  = s[i];
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random(int span);
      logic [31:0] o[3], d[3], m[3];
      logic [30:0] s[3];
      for (int i = 0; i < 3; i++) begin
         o[i] = pick_coord(span);
         d[i] = $urandom_range(0, 5) == 0 ? 32'd0 : pick_coord(span);
         s[i] = pick_size(span);
         // mostly aim the box near the ray's path
         m[i] = $urandom_range(0, 2) == 0 ? pick_coord(span)
              : o[i] + d[i] * $urandom_range(0, 4) - (s[i] >> 1);
      end
      send_ray(o, d, m, s);
   endtask

   initial begin
      logic [31:0] o[3], d[3], m[3];
      logic [30:0] s[3];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      cycles     = 0;
      calm       = 1'b0;
      repeat (7) @(negedge clock);
      reset = 1'b0;
      // directed: straight hit, miss, parallel inside/outside/edge, extremes
      o = '{0, 0, 0}; d = '{32'h10000, 0, 0};
      m = '{32'h50000, -32'sh10000, -32'sh10000}; s = '{31'h20000, 31'h20000, 31'h20000};
      send_ray(o, d, m, s);
      m = '{32'h50000, 32'h10000, -32'sh10000};
      send_ray(o, d, m, s);
      m = '{32'h50000, 32'd0, -32'sh20000};
      send_ray(o, d, m, s);
      d = '{-32'sh10000, 0, 0};
      m = '{32'h50000, -32'sh10000, -32'sh10000};
      send_ray(o, d, m, s);
      o = '{32'h8000_0000, 32'h7fff_ffff, 0}; d = '{1, -1, 32'h7fff_ffff};
      m = '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000};
      s = '{31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff};
      send_ray(o, d, m, s);
      d = '{32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff};
      send_ray(o, d, m, s);
      o = '{0, 0, 0}; d = '{32'h10000, 32'h10000, 32'h10000};
      m = '{32'h10000, 32'h10000, 32'h10000}; s = '{31'd0, 31'd0, 31'd0};
      send_ray(o, d, m, s);
      o = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
      d = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
      m = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
      s = '{31'h7fff_ffff, 31'h2aaa_aaaa, 31'h5555_5555};
      send_ray(o, d, m, s);
      for (int k = 0; k < 12; k++) send_random(32'h7fff_ffff);
      for (int k = 0; k < 1030; k++) begin
         if (k == 900) calm = 1'b1;
         send_random(k % 3 == 0 ? 32'h7fff_ffff : 32'h0004_0000);
      end
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
